// ----- rtl/mdeb_pkg.sv -----
// Shared constants, types and helpers for the multichannel input debounce block.
package mdeb_pkg;

   localparam int CHANNELS    = 32;
   localparam int COUNT_WIDTH = 8;

   localparam int SAMPLE_WIDTH    = 32;
   localparam int CFG_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH = 8;

   // compare width covers both the counters and the 8-bit registers
   localparam int CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_LENGTH   = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VALID_THRESHOLD = CSR_INDEX_WIDTH'(1);

   localparam logic [CFG_WIDTH-1:0] FILTER_LENGTH_RESET   = CFG_WIDTH'(10);
   localparam logic [CFG_WIDTH-1:0] VALID_THRESHOLD_RESET = CFG_WIDTH'(5);

   // control shared by every lane
   typedef struct packed {
      logic                   accept;
      logic [COUNT_WIDTH-1:0] ceiling;
      logic [CMP_WIDTH-1:0]   threshold;
   } lane_ctl_type;

   // status of the output buffer
   typedef struct packed {
      logic valid;
      logic full;
   } buf_status_type;

   // clamp the filter length to what the counters can hold
   function automatic logic [COUNT_WIDTH-1:0] ceiling_of(input logic [CFG_WIDTH-1:0] len);
      logic [CMP_WIDTH-1:0] f;
      logic [CMP_WIDTH-1:0] m;
      f = CMP_WIDTH'(len);
      m = CMP_WIDTH'(COUNT_MAX);
      return (f < m) ? COUNT_WIDTH'(f) : COUNT_WIDTH'(m);
   endfunction

endpackage

// ----- rtl/mdeb_lane.sv -----
// One debounce lane: high and low counters and the filtered level of one channel.
module mdeb_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  mdeb_pkg::lane_ctl_type ctl,
   input  logic                  raw_bit,
   output logic                  level_next
);

   logic [mdeb_pkg::COUNT_WIDTH-1:0] high_ff, high_in;
   logic [mdeb_pkg::COUNT_WIDTH-1:0] low_ff, low_in;
   logic                             level_ff, level_in;

   always_comb begin
      high_in  = high_ff;
      low_in   = low_ff;
      level_in = level_ff;
      if (ctl.accept) begin
         if (raw_bit) begin
            if (high_ff < ctl.ceiling) high_in = high_ff + mdeb_pkg::COUNT_WIDTH'(1);
            if (low_ff != '0)          low_in  = low_ff - mdeb_pkg::COUNT_WIDTH'(1);
         end else begin
            if (low_ff < ctl.ceiling)  low_in  = low_ff + mdeb_pkg::COUNT_WIDTH'(1);
            if (high_ff != '0)         high_in = high_ff - mdeb_pkg::COUNT_WIDTH'(1);
         end
         if (mdeb_pkg::CMP_WIDTH'(high_in) >= ctl.threshold) begin
            level_in = 1'b1;
         end else if (mdeb_pkg::CMP_WIDTH'(low_in) >= ctl.threshold) begin
            level_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff  <= '0;
         low_ff   <= '0;
         level_ff <= 1'b0;
      end else begin
         high_ff  <= high_in;
         low_ff   <= low_in;
         level_ff <= level_in;
      end
   end

   assign level_next = level_in;

endmodule

// ----- rtl/mdeb_merge.sv -----
// Merge of the lane levels into the result vector, held in a two-entry output buffer.
module mdeb_merge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic [mdeb_pkg::CHANNELS-1:0]       levels,
   input  logic                                pop,
   output mdeb_pkg::buf_status_type            status,
   output logic [mdeb_pkg::SAMPLE_WIDTH-1:0]   data
);

   logic [mdeb_pkg::SAMPLE_WIDTH-1:0] merged;
   logic [mdeb_pkg::SAMPLE_WIDTH-1:0] head_ff, head_in;
   logic [mdeb_pkg::SAMPLE_WIDTH-1:0] tail_ff, tail_in;
   logic [1:0]                        count_ff, count_in;

   // reported bits come from the lanes, bits without a lane read 0
   for (genvar i = 0; i < mdeb_pkg::SAMPLE_WIDTH; i++) begin : g_bit
      if (i < mdeb_pkg::CHANNELS) begin : g_lane
         assign merged[i] = levels[i];
      end else begin : g_none
         assign merged[i] = 1'b0;
      end
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) head_in = merged;
            else                  tail_in = merged;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            // advance the head and refill behind it
            if (count_ff == 2'd1) begin
               head_in = merged;
            end else begin
               head_in = tail_ff;
               tail_in = merged;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 2'd0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign data         = head_ff;

endmodule

// ----- rtl/multichannel_input_debounce_unit.sv -----
// Top level of the multichannel input debounce block.
// Each transfer on the req_ channel is one scan of all input channels, one raw
// bit per channel in req_raw_sample. Every channel runs its own lane with a
// saturating high and low counter; the filtered vector after the update
// leaves on the rsp_ channel as rsp_filtered_levels.
// The filtered vector of each scan is registered in the output buffer.
// Throughput: one scan per cycle while req_stall is low.
// A two-entry output buffer lets a scan enter while a result still waits;
// req_stall rises only when both entries are held by a stalled receiver.
// csr_ writes set filter_length (index 0) and valid_threshold (index 1);
// csr_ready is always high and other indexes are dropped. Write only while
// idle.
// Reset clears all counters and levels, empties the output buffer and loads
// filter_length = 10 and valid_threshold = 5.
module multichannel_input_debounce_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [mdeb_pkg::SAMPLE_WIDTH-1:0]      req_raw_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [mdeb_pkg::SAMPLE_WIDTH-1:0]      rsp_filtered_levels,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mdeb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [mdeb_pkg::CFG_WIDTH-1:0]         csr_wdata
);

   logic [mdeb_pkg::CFG_WIDTH-1:0] filter_length_ff, filter_length_in;
   logic [mdeb_pkg::CFG_WIDTH-1:0] valid_threshold_ff, valid_threshold_in;

   mdeb_pkg::lane_ctl_type      lane_ctl;
   mdeb_pkg::buf_status_type    buf_status;
   logic [mdeb_pkg::CHANNELS-1:0] levels;
   logic                        req_accept;
   logic                        rsp_accept;

   assign csr_ready = 1'b1;

   always_comb begin
      filter_length_in   = filter_length_ff;
      valid_threshold_in = valid_threshold_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mdeb_pkg::CSR_FILTER_LENGTH:   filter_length_in   = csr_wdata;
            mdeb_pkg::CSR_VALID_THRESHOLD: valid_threshold_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_length_ff   <= mdeb_pkg::FILTER_LENGTH_RESET;
         valid_threshold_ff <= mdeb_pkg::VALID_THRESHOLD_RESET;
      end else begin
         filter_length_ff   <= filter_length_in;
         valid_threshold_ff <= valid_threshold_in;
      end
   end

   assign req_stall  = buf_status.full;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = buf_status.valid;
   assign rsp_accept = rsp_valid && !rsp_stall;

   assign lane_ctl.accept    = req_accept;
   assign lane_ctl.ceiling   = mdeb_pkg::ceiling_of(filter_length_ff);
   assign lane_ctl.threshold = mdeb_pkg::CMP_WIDTH'(valid_threshold_ff);

   for (genvar c = 0; c < mdeb_pkg::CHANNELS; c++) begin : g_lane
      logic raw_bit;
      // channels past the sample width see a raw 0
      if (c < mdeb_pkg::SAMPLE_WIDTH) begin : g_in
         assign raw_bit = req_raw_sample[c];
      end else begin : g_zero
         assign raw_bit = 1'b0;
      end
      mdeb_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctl        (lane_ctl),
         .raw_bit    (raw_bit),
         .level_next (levels[c])
      );
   end

   mdeb_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .push   (req_accept),
      .levels (levels),
      .pop    (rsp_accept),
      .status (buf_status),
      .data   (rsp_filtered_levels)
   );

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("transfer in did not leave a result");

   a_full_has_valid: assert property (@(posedge clock) disable iff (reset)
      buf_status.full |-> buf_status.valid)
      else $error("buffer full but empty");

   a_stall_needs_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_accept))
      else $error("buffer filled without an input transfer");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_filtered_levels)))
      else $error("stalled result changed");

endmodule
